>>> src/uv_sphere_vertex_index_generator_defines.svh
// ----------------------------------------------------------------------------
// UV sphere generator assertion macros
// Concurrent assertion helpers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_INDEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_INDEX_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define UVS_ASSERT_IMP(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("assertion failed: cond implies expr");
// Next-cycle implication.
`define UVS_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed: cond implies expr in next cycle");
`else
`define UVS_ASSERT_IMP(label, cond, expr)
`define UVS_ASSERT_NEXT(label, cond, expr)
`endif

`endif

>>> src/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int MAX_SECTORS  = 256;
	localparam int MAX_STACKS   = 256;
	localparam int TURN_BITS    = 24;
	localparam int CORDIC_STEPS = 18;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int MID_LAT      = TURN_BITS + CORDIC_LAT;
	localparam int CNT_W        = 9;
	localparam int IDX_W        = 17;

	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032875;

	localparam logic [21:0] ARC_TAB [CORDIC_STEPS] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
		22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304,
		22'd652, 22'd326, 22'd163, 22'd81, 22'd41, 22'd20
	};

	// Configuration register indexes.
	localparam logic CFG_SECTOR_COUNT = 1'b0;
	localparam logic CFG_STACK_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_REJECT   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SEL_VERTEX = 2'd0,
		SEL_FIRST  = 2'd1,
		SEL_SECOND = 2'd2
	} sel_t;

	// Per-point control data that travels beside the arithmetic lanes.
	typedef struct packed {
		logic             reject;
		logic             first;
		logic             second;
		logic [IDX_W-1:0] k1;
		logic [IDX_W-1:0] k2;
	} meta_t;

	// Saturate a Q15 value to the symmetric range.
	function automatic logic signed [15:0] sat_q15(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			return 16'sd32767;
		end else if (v < -19'sd32767) begin
			return -16'sd32767;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

>>> src/uvs_if.sv
// ----------------------------------------------------------------------------
// UV sphere generator channels
// Grid point input channel and result output channel.
// ----------------------------------------------------------------------------
interface uvs_point_if;
	logic       valid;
	logic       ready;
	logic [8:0] stack_index;
	logic [8:0] sector_index;

	modport source(output valid, stack_index, sector_index, input ready);
	modport sink(input valid, stack_index, sector_index, output ready);
endinterface

interface uvs_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [16:0]        corner_a;
	logic [16:0]        corner_b;
	logic [16:0]        corner_c;
	logic               last;

	modport source(output valid, kind, pos_x, pos_y, pos_z, corner_a, corner_b,
		corner_c, last, input ready);
	modport sink(input valid, kind, pos_x, pos_y, pos_z, corner_a, corner_b,
		corner_c, last, output ready);
endinterface

>>> src/uvs_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined phase divider
// Computes floor((top * 2^24 + low) / d) with one quotient bit per stage after the first, which yields two.
// top must not exceed d, so the quotient fits in 25 bits.
// ----------------------------------------------------------------------------
module uvs_div_pipe
	import uvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [CNT_W-1:0]     top,
	input  logic [TURN_BITS-1:0] low,
	input  logic [CNT_W-1:0]     d,
	output logic [TURN_BITS:0]   quo
);

	logic [CNT_W-1:0]     rem_s [TURN_BITS];
	logic [TURN_BITS:0]   quo_s [TURN_BITS];
	logic [TURN_BITS-1:0] low_s [TURN_BITS];

	logic             q_top;
	logic [CNT_W-1:0] r_top;
	logic [CNT_W:0]   t0;
	logic             q0;

	// First stage: leading quotient bit, then the first long-division step.
	always_comb begin
		q_top = (top >= d);
		r_top = q_top ? (top - d) : top;
		t0    = {r_top, low[TURN_BITS-1]};
		q0    = (t0 >= {1'b0, d});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= q0 ? CNT_W'(t0 - {1'b0, d}) : t0[CNT_W-1:0];
			quo_s[0] <= {{(TURN_BITS-1){1'b0}}, q_top, q0};
			low_s[0] <= {low[TURN_BITS-2:0], 1'b0};
		end
	end

	// Remaining stages bring down one numerator bit each.
	for (genvar k = 1; k < TURN_BITS; k++) begin : g_step
		logic [CNT_W:0] t;
		logic           qb;

		always_comb begin
			t  = {rem_s[k-1], low_s[k-1][TURN_BITS-1]};
			qb = (t >= {1'b0, d});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= qb ? CNT_W'(t - {1'b0, d}) : t[CNT_W-1:0];
				quo_s[k] <= {quo_s[k-1][TURN_BITS-1:0], qb};
				low_s[k] <= {low_s[k-1][TURN_BITS-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[TURN_BITS-1];

endmodule

>>> src/uvs_cordic_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Folds a phase into the right half plane, runs one rotation per stage and
// returns cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module uvs_cordic_pipe
	import uvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [TURN_BITS-1:0] phase,
	output logic signed [31:0]   cos_v,
	output logic signed [31:0]   sin_v
);

	localparam logic [TURN_BITS-1:0] QUARTER = TURN_BITS'(1) << (TURN_BITS - 2);
	localparam logic [TURN_BITS-1:0] THREE_Q = TURN_BITS'(3) << (TURN_BITS - 2);

	logic signed [32:0] x_s   [CORDIC_STEPS+1];
	logic signed [32:0] y_s   [CORDIC_STEPS+1];
	logic signed [25:0] a_s   [CORDIC_STEPS+1];
	logic               neg_s [CORDIC_STEPS+1];

	logic signed [25:0] ang;
	logic               neg;

	// Fold: the middle half turn is rotated by a half turn and negated later.
	always_comb begin
		neg = 1'b0;
		if (phase >= QUARTER && phase < THREE_Q) begin
			ang = $signed({2'b00, phase}) - (26'sd1 <<< (TURN_BITS - 1));
			neg = 1'b1;
		end else if (phase >= THREE_Q) begin
			ang = $signed({2'b00, phase}) - (26'sd1 <<< TURN_BITS);
		end else begin
			ang = $signed({2'b00, phase});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= CORDIC_X0;
			y_s[0]   <= '0;
			a_s[0]   <= ang;
			neg_s[0] <= neg;
		end
	end

	// One rotation per stage with floor shifts.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [25:0] arc;

		always_comb begin
			dx  = y_s[k] >>> k;
			dy  = x_s[k] >>> k;
			arc = $signed({4'b0000, ARC_TAB[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (a_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					a_s[k+1] <= a_s[k] - arc;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					a_s[k+1] <= a_s[k] + arc;
				end
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// Undo the half-turn fold.
	logic signed [32:0] nx;
	logic signed [32:0] ny;

	always_comb begin
		nx = -x_s[CORDIC_STEPS];
		ny = -y_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= neg_s[CORDIC_STEPS] ? nx[31:0] : x_s[CORDIC_STEPS][31:0];
			sin_v <= neg_s[CORDIC_STEPS] ? ny[31:0] : y_s[CORDIC_STEPS][31:0];
		end
	end

endmodule

>>> src/uv_sphere_vertex_index_generator.sv
// ----------------------------------------------------------------------------
// UV sphere vertex and triangle index generator
// Emits the Q1.15 vertex of one sphere grid point and its quad triangles, or a reject.
// ----------------------------------------------------------------------------
// A grid point passes one entry register, a 24-stage divider that turns the
// stack and sector indexes into phases, a 20-stage CORDIC, a product register
// and a rounding register that holds the finished point. A point yields one
// to three results; the holding register presents them in order and the
// whole pipeline waits while it does, so the block takes one point per cycle
// when each point yields one result and the result channel does not stall; a
// point with more results holds back the next until its last one is taken.
// Write the sector and stack counts only while no point is in flight.
module uv_sphere_vertex_index_generator
	import uvs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	uvs_point_if.sink        point,
	uvs_result_if.source     result
);

	`include "uv_sphere_vertex_index_generator_defines.svh"

	// Configuration registers.
	logic [CNT_W-1:0] sector_count_q;
	logic [CNT_W-1:0] stack_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= CNT_W'(36);
			stack_count_q  <= CNT_W'(18);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SECTOR_COUNT: sector_count_q <= cfg_data;
				CFG_STACK_COUNT:  stack_count_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Effective counts.
	logic [CNT_W-1:0] s_cnt;
	logic [CNT_W-1:0] t_cnt;

	always_comb begin
		if (sector_count_q < CNT_W'(3)) begin
			s_cnt = CNT_W'(3);
		end else if (sector_count_q > CNT_W'(MAX_SECTORS)) begin
			s_cnt = CNT_W'(MAX_SECTORS);
		end else begin
			s_cnt = sector_count_q;
		end
		if (stack_count_q < CNT_W'(2)) begin
			t_cnt = CNT_W'(2);
		end else if (stack_count_q > CNT_W'(MAX_STACKS)) begin
			t_cnt = CNT_W'(MAX_STACKS);
		end else begin
			t_cnt = stack_count_q;
		end
	end

	logic adv;
	logic out_fire;

	// Entry stage: range check, triangle flags and vertex indexes.
	logic [CNT_W-1:0] i_in;
	logic [CNT_W-1:0] j_in;
	meta_t            meta_in;
	logic             tri_in;
	logic [IDX_W-1:0] row_base;

	always_comb begin
		i_in     = point.stack_index;
		j_in     = point.sector_index;
		tri_in   = (i_in < t_cnt) && (j_in < s_cnt);
		row_base = IDX_W'(i_in) * (IDX_W'(s_cnt) + IDX_W'(1));
		meta_in.reject = (i_in > t_cnt) || (j_in > s_cnt);
		meta_in.first  = tri_in && (i_in != '0);
		meta_in.second = tri_in && (i_in != t_cnt - CNT_W'(1));
		meta_in.k1     = row_base + IDX_W'(j_in);
		meta_in.k2     = row_base + IDX_W'(j_in) + IDX_W'(s_cnt) + IDX_W'(1);
	end

	logic                 valid_s1;
	meta_t                meta_s1;
	logic [CNT_W-1:0]     st_top_s1;
	logic [TURN_BITS-1:0] st_low_s1;
	logic [CNT_W-1:0]     se_top_s1;
	logic [TURN_BITS-1:0] se_low_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= point.valid;
		end
	end

	// Stack numerator is i * 2^23 + T/2; sector numerator is j * 2^24 + S/2.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1   <= meta_in;
			st_top_s1 <= {1'b0, i_in[CNT_W-1:1]};
			st_low_s1 <= {i_in[0], (TURN_BITS-1)'(t_cnt >> 1)};
			se_top_s1 <= j_in;
			se_low_s1 <= TURN_BITS'(s_cnt >> 1);
		end
	end

	// Phase division lanes.
	logic [TURN_BITS:0] st_quo;
	logic [TURN_BITS:0] se_quo;

	uvs_div_pipe u_div_stack (
		.clk (clk),
		.en  (adv),
		.top (st_top_s1),
		.low (st_low_s1),
		.d   (t_cnt),
		.quo (st_quo)
	);

	uvs_div_pipe u_div_sector (
		.clk (clk),
		.en  (adv),
		.top (se_top_s1),
		.low (se_low_s1),
		.d   (s_cnt),
		.quo (se_quo)
	);

	// Stack phase runs from a quarter turn down; both wrap modulo one turn.
	logic [TURN_BITS-1:0] st_phase;
	logic [TURN_BITS-1:0] se_phase;

	always_comb begin
		st_phase = (TURN_BITS'(1) << (TURN_BITS - 2)) - st_quo[TURN_BITS-1:0];
		se_phase = se_quo[TURN_BITS-1:0];
	end

	logic signed [31:0] ct;
	logic signed [31:0] st;
	logic signed [31:0] cs;
	logic signed [31:0] ss;

	uvs_cordic_pipe u_cordic_stack (
		.clk   (clk),
		.en    (adv),
		.phase (st_phase),
		.cos_v (ct),
		.sin_v (st)
	);

	uvs_cordic_pipe u_cordic_sector (
		.clk   (clk),
		.en    (adv),
		.phase (se_phase),
		.cos_v (cs),
		.sin_v (ss)
	);

	// Control data delay line matched to the divider and CORDIC lanes.
	logic  valid_s2 [MID_LAT];
	meta_t meta_s2  [MID_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MID_LAT; k++) begin
				valid_s2[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s2[0] <= valid_s1;
			for (int k = 1; k < MID_LAT; k++) begin
				valid_s2[k] <= valid_s2[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2[0] <= meta_s1;
			for (int k = 1; k < MID_LAT; k++) begin
				meta_s2[k] <= meta_s2[k-1];
			end
		end
	end

	// Product stage.
	logic               valid_s3;
	meta_t              meta_s3;
	logic signed [63:0] mx_s3;
	logic signed [63:0] my_s3;
	logic signed [31:0] sz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2[MID_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2[MID_LAT-1];
			mx_s3   <= ct * cs;
			my_s3   <= ct * ss;
			sz_s3   <= st;
		end
	end

	// Rounding and saturation to Q1.15, half rounded up.
	logic signed [63:0] rx;
	logic signed [63:0] ry;
	logic signed [32:0] rz;

	always_comb begin
		rx = mx_s3 + (64'sd1 <<< 44);
		ry = my_s3 + (64'sd1 <<< 44);
		rz = {sz_s3[31], sz_s3} + 33'sd16384;
	end

	logic               valid_s4;
	meta_t              meta_s4;
	logic signed [15:0] px_s4;
	logic signed [15:0] py_s4;
	logic signed [15:0] pz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			px_s4   <= sat_q15(rx[63:45]);
			py_s4   <= sat_q15(ry[63:45]);
			pz_s4   <= sat_q15({rz[32], rz[32:15]});
		end
	end

	// Result sequencer over the held point: vertex, first and second triangle.
	sel_t sel_q;
	sel_t sel_d;
	logic res_last;

	always_comb begin
		if (meta_s4.reject) begin
			res_last = 1'b1;
		end else begin
			case (sel_q)
				SEL_VERTEX: res_last = !(meta_s4.first || meta_s4.second);
				SEL_FIRST:  res_last = !meta_s4.second;
				SEL_SECOND: res_last = 1'b1;
				default:    res_last = 1'b1;
			endcase
		end
	end

	assign out_fire = result.valid && result.ready;
	assign adv      = !valid_s4 || (out_fire && res_last);
	assign point.ready = adv;

	// Next result selection.
	always_comb begin
		sel_d = sel_q;
		if (adv) begin
			sel_d = SEL_VERTEX;
		end else if (out_fire) begin
			sel_d = (sel_q == SEL_VERTEX && meta_s4.first) ? SEL_FIRST : SEL_SECOND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_VERTEX;
		end else begin
			sel_q <= sel_d;
		end
	end

	// Result fields for the current selection.
	always_comb begin
		result.valid    = valid_s4;
		result.last     = res_last;
		result.kind     = KIND_VERTEX;
		result.pos_x    = '0;
		result.pos_y    = '0;
		result.pos_z    = '0;
		result.corner_a = '0;
		result.corner_b = '0;
		result.corner_c = '0;
		if (meta_s4.reject) begin
			result.kind = KIND_REJECT;
		end else begin
			case (sel_q)
				SEL_VERTEX: begin
					result.pos_x = px_s4;
					result.pos_y = py_s4;
					result.pos_z = pz_s4;
				end
				SEL_FIRST: begin
					result.kind     = KIND_TRIANGLE;
					result.corner_a = meta_s4.k1;
					result.corner_b = meta_s4.k2;
					result.corner_c = meta_s4.k1 + IDX_W'(1);
				end
				SEL_SECOND: begin
					result.kind     = KIND_TRIANGLE;
					result.corner_a = meta_s4.k1 + IDX_W'(1);
					result.corner_b = meta_s4.k2;
					result.corner_c = meta_s4.k2 + IDX_W'(1);
				end
				default: ;
			endcase
		end
	end

	// A rejected point always ends in its single result.
	`UVS_ASSERT_IMP(a_reject_last, result.valid && meta_s4.reject, result.last)
	// The second triangle is only presented for points that have one.
	`UVS_ASSERT_IMP(a_second_sel, valid_s4 && sel_q == SEL_SECOND, meta_s4.second)
	// A held point whose results are not all transferred stays held.
	`UVS_ASSERT_NEXT(a_hold_point, valid_s4 && !adv, valid_s4)

endmodule
